// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbd assertion failed");

// Next-cycle implication, disabled while in reset.
`define RBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbd assertion failed");

`endif

// ===== src/rbd_pkg.sv =====
// Package for the RGB332 box downscaler: widths, types and helper functions.
// No dependencies; used by every module of the block.
package rbd_pkg;

    localparam int MAX_OUT_WIDTH  = 800;
    localparam int MAX_OUT_HEIGHT = 600;
    localparam int MAX_IN_DIM     = 4096;

    localparam int DIM_W      = 13;   // configured dimension
    localparam int CNT_W      = 12;   // input position counters
    localparam int COORD_W    = 10;   // reduced-image coordinates
    localparam int SCALE_W    = 3;
    localparam int MAX_SCALE  = 7;
    localparam int PIX_W      = 8;
    localparam int RG_SUM_W   = 9;    // 49 * 7 fits
    localparam int B_SUM_W    = 8;    // 49 * 3 fits
    localparam int RECIP_W    = 17;
    localparam int RECIP_SH   = 16;
    localparam int SUM_DEPTH  = 1024;
    localparam int SUM_AW     = 10;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 1'b0,
        REG_IN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [RG_SUM_W-1:0] r;
        logic [RG_SUM_W-1:0] g;
        logic [B_SUM_W-1:0]  b;
    } sums_t;

    // Per-pixel control from the scan counters.
    typedef struct packed {
        logic               first;       // first pixel of its block
        logic               last_blk;    // last pixel of its block
        logic               whole;       // pixel lies in a whole block
        logic               last_frame;  // block is the final one of the frame
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pix_ctl_t;

    // Finished block sums on their way to the divider.
    typedef struct packed {
        sums_t              sums;
        logic               last_frame;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } blk_sum_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_IN_DIM)
            r = DIM_W'(MAX_IN_DIM);
        return r;
    endfunction

    // Smallest s with w/s <= MAX_OUT_WIDTH and h/s <= MAX_OUT_HEIGHT,
    // i.e. w < s*(MAX_OUT_WIDTH+1) and h < s*(MAX_OUT_HEIGHT+1).
    function automatic logic [SCALE_W-1:0] derive_scale(input logic [DIM_W-1:0] w,
                                                        input logic [DIM_W-1:0] h);
        logic [SCALE_W-1:0] sw;
        logic [SCALE_W-1:0] sh;
        sw = SCALE_W'(1);
        sh = SCALE_W'(1);
        for (int k = 1; k < MAX_SCALE; k++)
        begin
            if (32'(w) >= k * (MAX_OUT_WIDTH + 1))
                sw = SCALE_W'(k + 1);
            if (32'(h) >= k * (MAX_OUT_HEIGHT + 1))
                sh = SCALE_W'(k + 1);
        end
        return (sw > sh) ? sw : sh;
    endfunction

    // ceil(2^16 / s^2); exact floor for sums below 512.
    function automatic logic [RECIP_W-1:0] area_recip(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            3'd1:    r = RECIP_W'(65536);
            3'd2:    r = RECIP_W'(16384);
            3'd3:    r = RECIP_W'(7282);
            3'd4:    r = RECIP_W'(4096);
            3'd5:    r = RECIP_W'(2622);
            3'd6:    r = RECIP_W'(1821);
            3'd7:    r = RECIP_W'(1338);
            default: r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

// ===== src/rbd_scan.sv =====
// Raster position counters, dimension registers and scale derivation.
// Depends on rbd_pkg.
module rbd_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbd_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          accept,
    output rbd_pkg::pix_ctl_t             ctl,
    output logic [rbd_pkg::RECIP_W-1:0]   recip
);

    logic [rbd_pkg::DIM_W-1:0]   eff_w_reg, eff_w_next;
    logic [rbd_pkg::DIM_W-1:0]   eff_h_reg, eff_h_next;
    logic [rbd_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [rbd_pkg::RECIP_W-1:0] recip_reg, recip_next;

    logic [rbd_pkg::CNT_W-1:0]   in_col_reg, in_col_next;
    logic [rbd_pkg::CNT_W-1:0]   in_row_reg, in_row_next;
    logic [rbd_pkg::CNT_W-1:0]   col_base_reg, col_base_next;
    logic [rbd_pkg::CNT_W-1:0]   row_base_reg, row_base_next;
    logic [rbd_pkg::SCALE_W-1:0] sub_col_reg, sub_col_next;
    logic [rbd_pkg::SCALE_W-1:0] sub_row_reg, sub_row_next;
    logic [rbd_pkg::COORD_W-1:0] blk_col_reg, blk_col_next;
    logic [rbd_pkg::COORD_W-1:0] blk_row_reg, blk_row_next;

    logic                        cfg_hit;
    logic [rbd_pkg::DIM_W-1:0]   new_w, new_h;
    logic [rbd_pkg::DIM_W-1:0]   scale_ext, scale_x2;
    logic [rbd_pkg::DIM_W-1:0]   col_end1, col_end2, row_end1, row_end2;
    logic [rbd_pkg::SCALE_W:0]   sub_col_inc, sub_row_inc;

    // Block whole when base + s <= dim; last whole block when base + 2s > dim.
    assign scale_ext = rbd_pkg::DIM_W'(scale_reg);
    assign scale_x2  = {scale_ext[rbd_pkg::DIM_W-2:0], 1'b0};
    assign col_end1  = rbd_pkg::DIM_W'(col_base_reg) + scale_ext;
    assign col_end2  = rbd_pkg::DIM_W'(col_base_reg) + scale_x2;
    assign row_end1  = rbd_pkg::DIM_W'(row_base_reg) + scale_ext;
    assign row_end2  = rbd_pkg::DIM_W'(row_base_reg) + scale_x2;

    always_comb
    begin
        ctl.first      = (sub_col_reg == '0) && (sub_row_reg == '0);
        ctl.last_blk   = (sub_col_reg == scale_reg - 1'b1) &&
                         (sub_row_reg == scale_reg - 1'b1);
        ctl.whole      = (col_end1 <= eff_w_reg) && (row_end1 <= eff_h_reg);
        ctl.last_frame = (col_end2 > eff_w_reg) && (row_end2 > eff_h_reg);
        ctl.col        = blk_col_reg;
        ctl.row        = blk_row_reg;
    end

    assign recip       = recip_reg;
    assign sub_col_inc = {1'b0, sub_col_reg} + 1'b1;
    assign sub_row_inc = {1'b0, sub_row_reg} + 1'b1;

    always_comb
    begin
        cfg_hit = 1'b0;
        new_w   = eff_w_reg;
        new_h   = eff_h_reg;
        case (cfg_index)
            rbd_pkg::REG_IN_WIDTH:
            begin
                cfg_hit = cfg_we;
                new_w   = rbd_pkg::clamp_dim(cfg_data);
            end
            rbd_pkg::REG_IN_HEIGHT:
            begin
                cfg_hit = cfg_we;
                new_h   = rbd_pkg::clamp_dim(cfg_data);
            end
            default:
            begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        eff_w_next    = eff_w_reg;
        eff_h_next    = eff_h_reg;
        scale_next    = scale_reg;
        recip_next    = recip_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        sub_col_next  = sub_col_reg;
        sub_row_next  = sub_row_reg;
        blk_col_next  = blk_col_reg;
        blk_row_next  = blk_row_reg;

        if (cfg_hit)
        begin
            // New geometry: rescale and restart the frame.
            eff_w_next    = new_w;
            eff_h_next    = new_h;
            scale_next    = rbd_pkg::derive_scale(new_w, new_h);
            recip_next    = rbd_pkg::area_recip(scale_next);
            in_col_next   = '0;
            in_row_next   = '0;
            col_base_next = '0;
            row_base_next = '0;
            sub_col_next  = '0;
            sub_row_next  = '0;
            blk_col_next  = '0;
            blk_row_next  = '0;
        end
        else if (accept)
        begin
            if (rbd_pkg::DIM_W'(in_col_reg) + 1'b1 >= eff_w_reg)
            begin
                in_col_next   = '0;
                col_base_next = '0;
                sub_col_next  = '0;
                blk_col_next  = '0;
                if (rbd_pkg::DIM_W'(in_row_reg) + 1'b1 >= eff_h_reg)
                begin
                    in_row_next   = '0;
                    row_base_next = '0;
                    sub_row_next  = '0;
                    blk_row_next  = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + 1'b1;
                    if (sub_row_inc >= {1'b0, scale_reg})
                    begin
                        sub_row_next  = '0;
                        blk_row_next  = blk_row_reg + 1'b1;
                        row_base_next = in_row_reg + 1'b1;
                    end
                    else
                    begin
                        sub_row_next = sub_row_inc[rbd_pkg::SCALE_W-1:0];
                    end
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
                if (sub_col_inc >= {1'b0, scale_reg})
                begin
                    sub_col_next  = '0;
                    blk_col_next  = blk_col_reg + 1'b1;
                    col_base_next = in_col_reg + 1'b1;
                end
                else
                begin
                    sub_col_next = sub_col_inc[rbd_pkg::SCALE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg    <= rbd_pkg::DIM_W'(rbd_pkg::MAX_OUT_WIDTH);
            eff_h_reg    <= rbd_pkg::DIM_W'(rbd_pkg::MAX_OUT_HEIGHT);
            scale_reg    <= rbd_pkg::SCALE_W'(1);
            recip_reg    <= rbd_pkg::area_recip(rbd_pkg::SCALE_W'(1));
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            blk_col_reg  <= '0;
            blk_row_reg  <= '0;
        end
        else
        begin
            eff_w_reg    <= eff_w_next;
            eff_h_reg    <= eff_h_next;
            scale_reg    <= scale_next;
            recip_reg    <= recip_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
            blk_col_reg  <= blk_col_next;
            blk_row_reg  <= blk_row_next;
        end
    end

endmodule

// ===== src/rbd_accum.sv =====
// Column-sum memory with read-modify-write and one-deep write forwarding.
// Depends on rbd_pkg.
module rbd_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        accept,
    input  logic [rbd_pkg::PIX_W-1:0]   pixel,
    input  rbd_pkg::pix_ctl_t           ctl,
    output logic                        blk_valid,
    output rbd_pkg::blk_sum_t           blk
);

    rbd_pkg::sums_t             mem [rbd_pkg::SUM_DEPTH];
    rbd_pkg::sums_t             rd_data_reg;

    logic                       s1_valid_reg;
    rbd_pkg::pix_ctl_t          s1_ctl_reg;
    logic [rbd_pkg::PIX_W-1:0]  s1_px_reg;

    logic                       fwd_valid_reg;
    logic [rbd_pkg::SUM_AW-1:0] fwd_addr_reg;
    rbd_pkg::sums_t             fwd_data_reg;

    logic                       s2_valid_reg;
    rbd_pkg::blk_sum_t          s2_reg;

    rbd_pkg::sums_t             base;
    rbd_pkg::sums_t             new_sum;
    logic                       wr_en;
    logic [rbd_pkg::SUM_AW-1:0] s1_addr;

    assign s1_addr = rbd_pkg::SUM_AW'(s1_ctl_reg.col);
    assign wr_en   = adv && s1_valid_reg && s1_ctl_reg.whole;

    // The entry written on the edge this pixel was read is not in rd_data.
    always_comb
    begin
        if (s1_ctl_reg.first)
            base = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
            base = fwd_data_reg;
        else
            base = rd_data_reg;
        new_sum.r = base.r + rbd_pkg::RG_SUM_W'(s1_px_reg[7:5]);
        new_sum.g = base.g + rbd_pkg::RG_SUM_W'(s1_px_reg[4:2]);
        new_sum.b = base.b + rbd_pkg::B_SUM_W'(s1_px_reg[1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_addr] <= new_sum;
        if (accept)
            rd_data_reg <= mem[rbd_pkg::SUM_AW'(ctl.col)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
            s2_valid_reg  <= wr_en && s1_ctl_reg.last_blk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                s1_ctl_reg <= ctl;
                s1_px_reg  <= pixel;
            end
            fwd_addr_reg       <= s1_addr;
            fwd_data_reg       <= new_sum;
            s2_reg.sums        <= new_sum;
            s2_reg.last_frame  <= s1_ctl_reg.last_frame;
            s2_reg.col         <= s1_ctl_reg.col;
            s2_reg.row         <= s1_ctl_reg.row;
        end
    end

    assign blk_valid = s2_valid_reg;
    assign blk       = s2_reg;

endmodule

// ===== src/rbd_avg.sv =====
// Divides block sums by scale squared via reciprocal multiply; output register.
// Depends on rbd_pkg.
module rbd_avg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          blk_valid,
    input  rbd_pkg::blk_sum_t             blk,
    input  logic [rbd_pkg::RECIP_W-1:0]   recip,
    output logic                          out_valid,
    output logic [rbd_pkg::PIX_W-1:0]     out_pixel,
    output logic [rbd_pkg::COORD_W-1:0]   out_col,
    output logic [rbd_pkg::COORD_W-1:0]   out_row,
    output logic                          last_of_frame
);

    localparam int PROD_W = rbd_pkg::RG_SUM_W + rbd_pkg::RECIP_W;
    localparam int SH     = rbd_pkg::RECIP_SH;

    logic [PROD_W-1:0]               prod_r, prod_g, prod_b;
    logic                            out_valid_reg;
    logic [rbd_pkg::PIX_W-1:0]       pixel_reg;
    logic [rbd_pkg::COORD_W-1:0]     col_reg, row_reg;
    logic                            last_reg;

    assign prod_r = PROD_W'(blk.sums.r) * PROD_W'(recip);
    assign prod_g = PROD_W'(blk.sums.g) * PROD_W'(recip);
    assign prod_b = PROD_W'(blk.sums.b) * PROD_W'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= blk_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && blk_valid)
        begin
            pixel_reg <= {prod_r[SH+2:SH], prod_g[SH+2:SH], prod_b[SH+1:SH]};
            col_reg   <= blk.col;
            row_reg   <= blk.row;
            last_reg  <= blk.last_frame;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pixel     = pixel_reg;
    assign out_col       = col_reg;
    assign out_row       = row_reg;
    assign last_of_frame = last_reg;

endmodule

// ===== src/rgb332_box_downscale.sv =====
// Pixel request accept to out_valid: read, accumulate and divide registers in turn.
// Throughput: 1 pixel per clock; the column-sum RAM (one read, one write a cycle,
// write forwarding) sets it. The input stalls only while a result waits at the output.
// Reset: counters to frame start, dimensions 800 x 600, scale 1; the column-sum
// RAM is not cleared since each block's first pixel overwrites its entry.
module rgb332_box_downscale (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: index 0 = in_width, 1 = in_height
    input  logic                          cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbd_pkg::DIM_W-1:0]     cfg_data,
    // pixel requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbd_pkg::PIX_W-1:0]     pixel,
    // averaged pixel requests
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rbd_pkg::PIX_W-1:0]     out_pixel,
    output logic [rbd_pkg::COORD_W-1:0]   out_col,
    output logic [rbd_pkg::COORD_W-1:0]   out_row,
    output logic                          last_of_frame
);

    // The whole pipe moves together; it holds only while the output
    // register is full and the consumer is not taking it.
    logic                        adv;
    logic                        accept;
    rbd_pkg::pix_ctl_t           ctl;
    logic [rbd_pkg::RECIP_W-1:0] recip;
    logic                        blk_valid;
    rbd_pkg::blk_sum_t           blk;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // Position counters and geometry: scale is the smallest integer
    // that maps the clamped input into 800 x 600.
    rbd_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .ctl       (ctl),
        .recip     (recip)
    );

    // Per-column sums: read on accept, then added and written back when the pipe advances.
    // Pixels outside whole blocks leave the RAM untouched.
    rbd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .pixel     (pixel),
        .ctl       (ctl),
        .blk_valid (blk_valid),
        .blk       (blk)
    );

    // Truncating divide by scale squared, repack, output register.
    rbd_avg u_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .blk_valid     (blk_valid),
        .blk           (blk),
        .recip         (recip),
        .out_valid     (out_valid),
        .out_pixel     (out_pixel),
        .out_col       (out_col),
        .out_row       (out_row),
        .last_of_frame (last_of_frame)
    );

endmodule

// ===== src/rbd_checker.sv =====
// Port-level checks for rgb332_box_downscale, attached by bind.
// Depends on rbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [rbd_pkg::PIX_W-1:0]     out_pixel,
    input  logic [rbd_pkg::COORD_W-1:0]   out_col,
    input  logic [rbd_pkg::COORD_W-1:0]   out_row,
    input  logic                          last_of_frame
);

    logic [rbd_pkg::PIX_W+2*rbd_pkg::COORD_W:0] out_word;
    logic                                       coord_ok;

    assign out_word = {out_pixel, out_col, out_row, last_of_frame};
    assign coord_ok = (out_col < rbd_pkg::COORD_W'(rbd_pkg::MAX_OUT_WIDTH)) &&
                      (out_row < rbd_pkg::COORD_W'(rbd_pkg::MAX_OUT_HEIGHT));

    // stalled result stays put
    `RBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `RBD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))
    // output backpressure reaches the input the same cycle
    `RBD_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
    // reduced coordinates never leave the 800 x 600 frame
    `RBD_ASSERT_IMP(a_coord_range, out_valid, coord_ok)

endmodule

bind rgb332_box_downscale rbd_checker u_rbd_checker (.*);
